// ===== hw/rtl/bkl_pkg.sv =====
// Shared constants for the bounded keyed list: capacity, derived widths,
// operation and status codes. No dependencies.
`timescale 1ns / 1ps

package bkl_pkg;

  // Number of entries the list can hold.
  localparam int unsigned CAPACITY = 64;

  // Field widths of one beat.
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned PAY_W       = 64;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned COUNT_OUT_W = 7;

  // Derived storage widths.
  localparam int unsigned ADDR_W  = $clog2(CAPACITY);
  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1);
  localparam int unsigned ENTRY_W = KEY_W + PAY_W;

  // Operation codes carried on the mode field.
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_ABSENT = 2'd2;

endpackage

// ===== hw/rtl/bkl_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. Standalone; no package dependency.
`timescale 1ns / 1ps

module bkl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/bounded_keyed_list.sv =====
// Top level of the bounded keyed list: control sequencer around one entry RAM.
// Depends on bkl_pkg and bkl_ram.
`timescale 1ns / 1ps

// Usage
// The input channel (in_valid_i / in_ready_o) carries one operation per beat:
// insert at the front, lookup by key, or remove by key. The output channel
// (out_valid_o / out_ready_i) returns exactly one result beat per operation,
// in order, with found flag, payload, entry count and status.
// Entries live in a single RAM in reverse order (the front of the list is the
// highest occupied address), so insert is a single write. Lookup and remove
// scan from the front with one read issued per cycle; remove then moves the
// entries ahead of the match one place down, one read and one write per cycle.
// Insert, a refused insert, an unused mode and a search of an empty list go
// straight to the hand-over state; a lookup or remove first scans, and a remove
// that hits then closes the gap before the hand-over.
// One operation is in flight at a time; a new beat is taken while the
// previous result still waits in the output register.
// Reset empties the list; RAM contents are not cleared and never read unset.
// When the receiver stalls, the result holds and the block stops once the
// next result is ready.
module bounded_keyed_list
  import bkl_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [MODE_W-1:0]      mode_i,
  input  logic [KEY_W-1:0]       key_i,
  input  logic [PAY_W-1:0]       payload_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   found_o,
  output logic [PAY_W-1:0]       found_payload_o,
  output logic [COUNT_OUT_W-1:0] entry_count_o,
  output logic [STATUS_W-1:0]    status_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_SHIFT  = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [MODE_W-1:0] mode_q, mode_d;
  logic [KEY_W-1:0]  key_q, key_d;

  logic                res_found_q, res_found_d;
  logic [PAY_W-1:0]    res_pay_q, res_pay_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;

  logic [ADDR_W-1:0] iss_addr_q, iss_addr_d;
  logic              iss_more_q, iss_more_d;
  logic              pend_q, pend_d;
  logic [ADDR_W-1:0] pend_addr_q, pend_addr_d;

  logic                   out_valid_q, out_valid_d;
  logic                   out_load;
  logic                   out_found_q;
  logic [PAY_W-1:0]       out_pay_q;
  logic [COUNT_OUT_W-1:0] out_count_q;
  logic [STATUS_W-1:0]    out_status_q;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [KEY_W-1:0]   rd_key;
  logic [PAY_W-1:0]   rd_pay;

  logic              in_accept;
  logic [ADDR_W-1:0] count_last;
  logic [CNT_W-1:0]  count_dec;

  // Entry storage, key in the upper bits.
  bkl_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(iss_addr_q),
    .rdata_o(ram_rdata)
  );

  assign rd_key = ram_rdata[ENTRY_W-1:PAY_W];
  assign rd_pay = ram_rdata[PAY_W-1:0];

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;

  // Address of the front entry; only used while the list is not empty.
  assign count_dec  = count_q - CNT_W'(1);
  assign count_last = count_dec[ADDR_W-1:0];

  // Sequencer: accept, scan, close the gap, hand the result over.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    mode_d       = mode_q;
    key_d        = key_q;
    res_found_d  = res_found_q;
    res_pay_d    = res_pay_q;
    res_status_d = res_status_q;
    iss_addr_d   = iss_addr_q;
    iss_more_d   = iss_more_q;
    pend_d       = pend_q;
    pend_addr_d  = pend_addr_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    out_load     = 1'b0;
    out_valid_d  = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          mode_d       = mode_i;
          key_d        = key_i;
          res_found_d  = 1'b0;
          res_pay_d    = '0;
          res_status_d = STAT_DONE;
          pend_d       = 1'b0;
          iss_more_d   = 1'b0;
          state_d      = ST_EMIT;
          priority if (mode_i == MODE_INSERT) begin
            if (count_q == CNT_W'(CAPACITY)) begin
              res_status_d = STAT_FULL;
            end else begin
              // New front entry goes just above the current front.
              ram_we    = 1'b1;
              ram_waddr = count_q[ADDR_W-1:0];
              ram_wdata = {key_i, payload_i};
              count_d   = count_q + CNT_W'(1);
            end
          end else if (mode_i == MODE_LOOKUP || mode_i == MODE_REMOVE) begin
            if (count_q == '0) begin
              res_status_d = STAT_ABSENT;
            end else begin
              iss_addr_d = count_last;
              iss_more_d = 1'b1;
              state_d    = ST_SEARCH;
            end
          end else begin
            // Unused mode: nothing changes.
            res_status_d = STAT_DONE;
          end
        end
      end

      ST_SEARCH: begin
        // Issue one read per cycle, walking from the front downward.
        ram_re      = iss_more_q;
        pend_d      = iss_more_q;
        pend_addr_d = iss_addr_q;
        if (iss_more_q) begin
          if (iss_addr_q == '0) begin
            iss_more_d = 1'b0;
          end else begin
            iss_addr_d = iss_addr_q - ADDR_W'(1);
          end
        end
        // Compare the entry read in the previous cycle.
        if (pend_q) begin
          if (rd_key == key_q) begin
            res_found_d = 1'b1;
            pend_d      = 1'b0;
            if (mode_q == MODE_LOOKUP) begin
              res_pay_d  = rd_pay;
              iss_more_d = 1'b0;
              state_d    = ST_EMIT;
            end else begin
              // Remove: pull every entry above the match down by one.
              iss_addr_d = pend_addr_q + ADDR_W'(1);
              iss_more_d = (pend_addr_q != count_last);
              state_d    = ST_SHIFT;
            end
          end else if (pend_addr_q == '0) begin
            res_status_d = STAT_ABSENT;
            pend_d       = 1'b0;
            iss_more_d   = 1'b0;
            state_d      = ST_EMIT;
          end
        end
      end

      ST_SHIFT: begin
        // Read entry j+1 this cycle, write it to j in the next.
        ram_re      = iss_more_q;
        pend_d      = iss_more_q;
        pend_addr_d = iss_addr_q;
        if (iss_more_q) begin
          if (iss_addr_q == count_last) begin
            iss_more_d = 1'b0;
          end else begin
            iss_addr_d = iss_addr_q + ADDR_W'(1);
          end
        end
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = pend_addr_q - ADDR_W'(1);
          ram_wdata = ram_rdata;
        end
        if (!iss_more_q && !pend_q) begin
          count_d = count_dec;
          state_d = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      iss_more_q  <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      iss_more_q  <= iss_more_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Operation and scan payload registers.
  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    key_q        <= key_d;
    res_found_q  <= res_found_d;
    res_pay_q    <= res_pay_d;
    res_status_q <= res_status_d;
    iss_addr_q   <= iss_addr_d;
    pend_addr_q  <= pend_addr_d;
  end

  // Output register, loaded when the result is handed over.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_found_q  <= res_found_q;
      out_pay_q    <= res_pay_q;
      out_count_q  <= COUNT_OUT_W'(count_q);
      out_status_q <= res_status_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = out_found_q;
  assign found_payload_o = out_pay_q;
  assign entry_count_o   = out_count_q;
  assign status_o        = out_status_q;

`ifndef NO_ASSERTIONS
  // The held count never goes past the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  // The count moves by at most one entry per operation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == $past(count_q) || count_q == $past(count_q) + CNT_W'(1) ||
    count_q == $past(count_q) - CNT_W'(1))
    else $error("entry count jumped");

  // Writes only land at or below the slot just above the front.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (CNT_W'(ram_waddr) <= count_q))
    else $error("RAM write outside the occupied range");

  // A new result only appears after the hand-over state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EMIT))
    else $error("result raised outside hand-over");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for bounded_keyed_list: a directed table, then phased
// random traffic, checked against typed table results or an in-bench list predictor.
// Depends on bkl_pkg and the bounded_keyed_list RTL.
`timescale 1ns / 1ps

module testbench;
  import bkl_pkg::*;

  localparam int unsigned CLK_PERIOD     = 20;
  localparam int unsigned RESET_CYCLES   = 5;
  localparam int unsigned MAX_IDLE       = 13;
  localparam int unsigned TOTAL_OPS      = 1850;
  // The limit below leaves ample margin over the slowest correct run of about 1900 beats.
  localparam int unsigned TIMEOUT_CYCLES = 1_500_000;
  localparam int unsigned DRAIN_CYCLES   = 2 * CAPACITY + 8;
  localparam int unsigned PLAN_ROWS      = 23;

  // The mode field has one code that the block ignores.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic                   found;
    logic [PAY_W-1:0]       payload;
    logic [COUNT_OUT_W-1:0] count;
    logic [STATUS_W-1:0]    status;
  } list_result_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key;
    logic [PAY_W-1:0]  payload;
    logic [7:0]        reps;
    logic              typed;
    list_result_t      res;
  } plan_row_t;

  typedef enum logic [1:0] {
    PH_FILL,
    PH_DRAIN,
    PH_CHURN,
    PH_NOISE
  } phase_kind_e;

  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic                   in_valid_i      = 1'b0;
  logic                   in_ready_o;
  logic [MODE_W-1:0]      mode_i          = MODE_INSERT;
  logic [KEY_W-1:0]       key_i           = '0;
  logic [PAY_W-1:0]       payload_i       = '0;
  logic                   out_valid_o;
  logic                   out_ready_i     = 1'b0;
  logic                   found_o;
  logic [PAY_W-1:0]       found_payload_o;
  logic [COUNT_OUT_W-1:0] entry_count_o;
  logic [STATUS_W-1:0]    status_o;

  // Shadow copy of the list, front at index 0.
  logic [KEY_W-1:0] shadow_keys [CAPACITY];
  logic [PAY_W-1:0] shadow_pays [CAPACITY];
  int unsigned      shadow_count = 0;

  list_result_t pending_results [$];

  bit          no_idle       = 1'b0;
  int unsigned fail_count    = 0;
  int unsigned ops_sent      = 0;
  int unsigned refused_count = 0;
  int unsigned hit_count     = 0;
  int unsigned miss_count    = 0;
  int unsigned full_visits   = 0;
  int unsigned empty_visits  = 0;
  int unsigned unused_count  = 0;

  // Directed stimulus: empty list, key and payload extremes, duplicates,
  // the unused mode, filling to capacity, then removes at front, near the back and middle.
  plan_row_t plan [PLAN_ROWS] = '{
    '{MODE_LOOKUP, 32'h0000_0000, 64'h0, 8'd1, 1'b1, '{1'b0, 64'h0, 7'd0, STAT_ABSENT}},
    '{MODE_REMOVE, 32'hFFFF_FFFF, 64'h0, 8'd1, 1'b1, '{1'b0, 64'h0, 7'd0, STAT_ABSENT}},
    '{MODE_INSERT, 32'hFFFF_FFFF, {PAY_W{1'b1}}, 8'd1, 1'b1,
      '{1'b0, 64'h0, 7'd1, STAT_DONE}},
    '{MODE_INSERT, 32'h0000_0000, 64'h0, 8'd1, 1'b1, '{1'b0, 64'h0, 7'd2, STAT_DONE}},
    '{MODE_LOOKUP, 32'hFFFF_FFFF, 64'h0, 8'd1, 1'b1,
      '{1'b1, {PAY_W{1'b1}}, 7'd2, STAT_DONE}},
    '{MODE_INSERT, 32'hFFFF_FFFF, 64'h5555_AAAA_0F0F_F0F0, 8'd1, 1'b1,
      '{1'b0, 64'h0, 7'd3, STAT_DONE}},
    '{MODE_LOOKUP, 32'hFFFF_FFFF, 64'h0, 8'd1, 1'b1,
      '{1'b1, 64'h5555_AAAA_0F0F_F0F0, 7'd3, STAT_DONE}},
    '{MODE_REMOVE, 32'hFFFF_FFFF, 64'h0, 8'd1, 1'b1, '{1'b1, 64'h0, 7'd2, STAT_DONE}},
    '{MODE_LOOKUP, 32'hFFFF_FFFF, 64'h0, 8'd1, 1'b1,
      '{1'b1, {PAY_W{1'b1}}, 7'd2, STAT_DONE}},
    '{MODE_UNUSED, 32'h0000_0000, {PAY_W{1'b1}}, 8'd1, 1'b1,
      '{1'b0, 64'h0, 7'd2, STAT_DONE}},
    '{MODE_LOOKUP, 32'h0000_0000, 64'h0, 8'd1, 1'b1, '{1'b1, 64'h0, 7'd2, STAT_DONE}},
    '{MODE_REMOVE, 32'h1234_5678, 64'h0, 8'd1, 1'b1, '{1'b0, 64'h0, 7'd2, STAT_ABSENT}},
    '{MODE_INSERT, 32'h8000_0000, 64'hA5A5_5A5A_C3C3_3C3C, 8'd62, 1'b0, '0},
    '{MODE_INSERT, 32'h0000_0007, 64'h1, 8'd1, 1'b1, '{1'b0, 64'h0, 7'd64, STAT_FULL}},
    '{MODE_LOOKUP, 32'h8000_001E, 64'h0, 8'd1, 1'b0, '0},
    '{MODE_LOOKUP, 32'h8000_0000, 64'h0, 8'd1, 1'b0, '0},
    '{MODE_REMOVE, 32'h8000_003D, 64'h0, 8'd1, 1'b1, '{1'b1, 64'h0, 7'd63, STAT_DONE}},
    '{MODE_REMOVE, 32'h0000_0000, 64'h0, 8'd1, 1'b1, '{1'b1, 64'h0, 7'd62, STAT_DONE}},
    '{MODE_REMOVE, 32'h8000_0010, 64'h0, 8'd1, 1'b1, '{1'b1, 64'h0, 7'd61, STAT_DONE}},
    '{MODE_LOOKUP, 32'h8000_0011, 64'h0, 8'd1, 1'b0, '0},
    '{MODE_LOOKUP, 32'hFFFF_FFFF, 64'h0, 8'd1, 1'b1,
      '{1'b1, {PAY_W{1'b1}}, 7'd61, STAT_DONE}},
    '{MODE_UNUSED, 32'hFFFF_FFFF, 64'h0, 8'd1, 1'b1, '{1'b0, 64'h0, 7'd61, STAT_DONE}},
    '{MODE_REMOVE, 32'h0000_0000, 64'h0, 8'd1, 1'b1, '{1'b0, 64'h0, 7'd61, STAT_ABSENT}}
  };

  bounded_keyed_list dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .key_i           (key_i),
    .payload_i       (payload_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .found_o         (found_o),
    .found_payload_o (found_payload_o),
    .entry_count_o   (entry_count_o),
    .status_o        (status_o)
  );

  // Free-running clock.
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Applies one operation to the shadow list and returns the result it causes.
  function automatic list_result_t predict_list_op(input logic [MODE_W-1:0] op,
                                                   input logic [KEY_W-1:0]  key,
                                                   input logic [PAY_W-1:0]  payload);
    list_result_t r;
    int unsigned  pos;
    int unsigned  i;
    r = '0;
    r.status = STAT_DONE;
    pos = 0;
    while (pos < shadow_count && shadow_keys[pos] != key) pos++;
    case (op)
      MODE_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          for (i = shadow_count; i > 0; i--) begin
            shadow_keys[i] = shadow_keys[i-1];
            shadow_pays[i] = shadow_pays[i-1];
          end
          shadow_keys[0] = key;
          shadow_pays[0] = payload;
          shadow_count++;
        end
      end
      MODE_LOOKUP: begin
        if (pos < shadow_count) begin
          r.found   = 1'b1;
          r.payload = shadow_pays[pos];
        end else begin
          r.status = STAT_ABSENT;
        end
      end
      MODE_REMOVE: begin
        if (pos < shadow_count) begin
          r.found = 1'b1;
          for (i = pos; i + 1 < shadow_count; i++) begin
            shadow_keys[i] = shadow_keys[i+1];
            shadow_pays[i] = shadow_pays[i+1];
          end
          shadow_count--;
        end else begin
          r.status = STAT_ABSENT;
        end
      end
      default: ;
    endcase
    r.count = COUNT_OUT_W'(shadow_count);
    return r;
  endfunction

  // Keys for searches mostly hit a held entry if the list is not empty; the rest
  // come from a small pool or the whole key range.
  function automatic logic [KEY_W-1:0] pick_search_key();
    if (shadow_count != 0 && $urandom_range(0, 3) != 0) begin
      return shadow_keys[$urandom_range(0, shadow_count - 1)];
    end
    if ($urandom_range(0, 1) == 0) return KEY_W'($urandom_range(0, 15));
    return $urandom();
  endfunction

  // Insert keys often repeat so that duplicates sit in the list.
  function automatic logic [KEY_W-1:0] pick_insert_key();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 6) return KEY_W'($urandom_range(0, 15));
    return $urandom();
  endfunction

  function automatic logic [PAY_W-1:0] pick_payload();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom(), $urandom()};
  endfunction

  // Drives one beat after a random gap, waits for the handshake and records
  // the result it must produce.
  task automatic send_op(input logic [MODE_W-1:0] op, input logic [KEY_W-1:0] key,
                         input logic [PAY_W-1:0] payload, input logic typed,
                         input list_result_t typed_res);
    int unsigned  gap;
    list_result_t predicted;
    gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= op;
    key_i      <= key;
    payload_i  <= payload;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    predicted = predict_list_op(op, key, payload);
    pending_results.push_back(typed ? typed_res : predicted);
    ops_sent++;
    if (predicted.status == STAT_FULL) refused_count++;
    if (op == MODE_UNUSED) unused_count++;
    if (op == MODE_LOOKUP || op == MODE_REMOVE) begin
      if (predicted.found) hit_count++;
      else miss_count++;
    end
    if (op == MODE_INSERT && predicted.status == STAT_DONE && shadow_count == CAPACITY) begin
      full_visits++;
    end
    if (op == MODE_REMOVE && predicted.found && shadow_count == 0) empty_visits++;
  endtask

  // Holds the input side idle until every outstanding result has been taken.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // Result side: random stalls on ready, then a field-by-field comparison
  // of each accepted beat with the oldest expectation.
  initial begin : result_sink
    int unsigned  stall;
    list_result_t want;
    wait (rst_ni === 1'b1);
    stall = 0;
    forever begin
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o === 1'b1 && out_ready_i));
      if (pending_results.size() == 0) begin
        $error("result beat arrived with no operation outstanding");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (found_o !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, found_o);
          fail_count++;
        end
        if (found_payload_o !== want.payload) begin
          $error("found_payload: expected %h, actual %h", want.payload, found_payload_o);
          fail_count++;
        end
        if (entry_count_o !== want.count) begin
          $error("entry_count: expected %0d, actual %0d", want.count, entry_count_o);
          fail_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          fail_count++;
        end
      end
      stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
    end
  end

  // Stimulus: reset, the directed table, then random phases.
  initial begin : stimulus
    phase_kind_e       phase;
    int unsigned       phase_len;
    int unsigned       r;
    logic [MODE_W-1:0] op;
    logic [KEY_W-1:0]  key;
    logic [PAY_W-1:0]  payload;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows; a repeated row steps its key by one per beat.
    foreach (plan[row]) begin
      for (int rep = 0; rep < plan[row].reps; rep++) begin
        send_op(plan[row].mode, plan[row].key + KEY_W'(rep), plan[row].payload,
                plan[row].typed && plan[row].reps == 1, plan[row].res);
      end
    end
    wait_for_results();

    // Random phases. The list level steers which phase comes next so that
    // the list keeps swinging between empty and full.
    while (ops_sent < TOTAL_OPS) begin
      r = $urandom_range(0, 9);
      if (shadow_count < 8 && r < 6) phase = PH_FILL;
      else if (shadow_count > 56 && r < 6) phase = PH_DRAIN;
      else if (r < 3) phase = PH_FILL;
      else if (r < 6) phase = PH_DRAIN;
      else if (r < 9) phase = PH_CHURN;
      else phase = PH_NOISE;
      phase_len = (phase == PH_FILL) ? $urandom_range(60, 150) : $urandom_range(20, 100);
      no_idle   = ($urandom_range(0, 3) == 0);

      for (int n = 0; n < phase_len && ops_sent < TOTAL_OPS; n++) begin
        r = $urandom_range(0, 99);
        payload = pick_payload();
        case (phase)
          PH_FILL: begin
            if (r < 75) op = MODE_INSERT;
            else if (r < 88) op = MODE_LOOKUP;
            else if (r < 95) op = MODE_REMOVE;
            else op = MODE_UNUSED;
          end
          PH_DRAIN: begin
            if (r < 65) op = MODE_REMOVE;
            else if (r < 85) op = MODE_LOOKUP;
            else if (r < 95) op = MODE_INSERT;
            else op = MODE_UNUSED;
          end
          PH_CHURN: begin
            if (r < 35) op = MODE_INSERT;
            else if (r < 65) op = MODE_LOOKUP;
            else if (r < 95) op = MODE_REMOVE;
            else op = MODE_UNUSED;
          end
          default: op = MODE_W'($urandom_range(0, 3));
        endcase
        if (phase == PH_NOISE) key = $urandom();
        else if (op == MODE_INSERT) key = pick_insert_key();
        else key = pick_search_key();
        send_op(op, key, payload, 1'b0, '0);
      end

      if ($urandom_range(0, 4) == 0) wait_for_results();
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) fail_count++;

    $display("Ran %0d operations: %0d refused inserts, %0d key hits, %0d key misses, %0d unused.",
             ops_sent, refused_count, hit_count, miss_count, unused_count);
    $display("The list was filled to capacity %0d times and emptied by removes %0d times.",
             full_visits, empty_visits);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Timed out with %0d results outstanding.", pending_results.size());
    $display("status: fail");
    $finish;
  end

endmodule
